[hw/rtl/lz_flag_word_decompress_top_defines.svh]
// Assertion macros used by the decompressor checker
`ifndef LZ_FLAG_WORD_DECOMPRESS_TOP_DEFINES_SVH
`define LZ_FLAG_WORD_DECOMPRESS_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define LZFW_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define LZFW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lzfw_pkg.sv]
// Constants and parser phase codes for the flag-word decompressor
package lzfw_pkg;

    localparam int HISTORY_DEPTH_DEF = 4096;

    localparam int CNT_W = 5;

    localparam logic [1:0] PH_FLAG_LO = 2'd0;
    localparam logic [1:0] PH_FLAG_HI = 2'd1;
    localparam logic [1:0] PH_ITEM    = 2'd2;
    localparam logic [1:0] PH_TOKEN   = 2'd3;

    localparam logic [16:0] FLAGS_EMPTY = 17'h00001;

    localparam logic [CNT_W-1:0] LEN_BASE = CNT_W'(3);

endpackage

[hw/rtl/lz_flag_word_decompress_top.sv]
// Flag-word LZSS decompressor with a history ring held in one synchronous memory
//
// Takes one compressed payload byte per request and returns the decoded bytes one per
// cycle on the output channel while out_ready is held high, run_last marking the final
// byte of each request. A flag byte or the first byte of a token produces nothing, and
// the next request can be taken at the following edge. A literal or a stored-mode byte
// produces one byte and holds off the input until that byte has moved into the output
// register. A token produces 3 to 18 bytes, one per cycle while out_ready is high, read
// back from the history ring through its single registered read port (a byte written
// in the same cycle is forwarded), so the next request is taken only once the last of
// them has moved into the output register. Holding out_ready low stalls the output and
// the intake of requests. The ring needs no clearing pass after reset: slots never
// written read as zero through a fill pointer, and the block is ready straight after
// reset. The user writes stored_mode only while the block is idle; nothing enforces it.
module lz_flag_word_decompress_top #(
    parameter int HISTORY_DEPTH = lzfw_pkg::HISTORY_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       stream_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    input  logic       cfg_write_en,
    input  logic       cfg_write_data
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_IDX  = AW'(HISTORY_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(HISTORY_DEPTH);

    logic                       stored_mode_reg;
    logic [1:0]                 phase_reg,  phase_next;
    logic [16:0]                flags_reg,  flags_next;
    logic [7:0]                 held_reg,   held_next;
    logic [AW-1:0]              wp_reg,     wp_next;
    logic                       filled_reg, filled_next;
    logic [AW-1:0]              rd_idx_reg;
    logic [lzfw_pkg::CNT_W-1:0] cnt_reg;

    logic       e_valid_reg;
    logic       e_from_mem_reg;
    logic       e_write_reg;
    logic       e_last_reg;
    logic       e_hit_reg;
    logic       e_fwd_reg;
    logic [7:0] e_data_reg;
    logic [7:0] rd_data_reg;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       run_last_reg;

    logic [7:0] ring_mem [HISTORY_DEPTH];

    logic                       in_fire;
    logic                       out_free;
    logic                       e_fire;
    logic [7:0]                 e_byte;
    logic                       wr_en;
    logic                       issue;
    logic                       rd_hit;
    logic                       rd_fwd;
    logic                       lit_load;
    logic                       tok_load;
    logic [11:0]                tok_dist;
    logic [lzfw_pkg::CNT_W-1:0] tok_len;
    logic [AW-1:0]              tok_start;
    logic [AW-1:0]              dist_ext;
    logic [16:0]                flags_shift;
    logic [AW-1:0]              rd_idx_inc;

    assign in_ready  = (cnt_reg == '0) && !e_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign e_fire    = e_valid_reg && out_free;
    assign wr_en     = e_fire && e_write_reg;
    assign issue     = (cnt_reg != '0) && (!e_valid_reg || e_fire);

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;

    always_comb
    begin
        if (!e_from_mem_reg)
        begin
            e_byte = e_data_reg;
        end
        else if (!e_hit_reg)
        begin
            e_byte = 8'h00;
        end
        else if (e_fwd_reg)
        begin
            e_byte = e_data_reg;
        end
        else
        begin
            e_byte = rd_data_reg;
        end
    end

    assign wp_next     = wr_en ? ((wp_reg == LAST_IDX) ? '0 : wp_reg + AW'(1)) : wp_reg;
    assign filled_next = filled_reg || (wr_en && (wp_reg == LAST_IDX));
    assign rd_hit      = filled_next || (rd_idx_reg < wp_next);
    assign rd_fwd      = wr_en && (rd_idx_reg == wp_reg);
    assign rd_idx_inc  = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + AW'(1);

    assign tok_dist  = {held_reg[7:4], in_byte};
    assign tok_len   = lzfw_pkg::LEN_BASE + lzfw_pkg::CNT_W'(held_reg[3:0]);
    assign dist_ext  = AW'(tok_dist);
    assign tok_start = (wp_reg >= dist_ext) ? wp_reg - dist_ext
                     : AW'({1'b0, wp_reg} + DEPTH_EXT - (AW+1)'(tok_dist));
    assign flags_shift = flags_reg >> 1;

    always_comb
    begin
        phase_next = phase_reg;
        flags_next = flags_reg;
        held_next  = held_reg;
        lit_load   = 1'b0;
        tok_load   = 1'b0;
        if (in_fire && !stored_mode_reg)
        begin
            unique case (phase_reg)
                lzfw_pkg::PH_FLAG_LO:
                begin
                    held_next  = in_byte;
                    phase_next = lzfw_pkg::PH_FLAG_HI;
                end
                lzfw_pkg::PH_FLAG_HI:
                begin
                    flags_next = {1'b1, in_byte, held_reg};
                    phase_next = lzfw_pkg::PH_ITEM;
                end
                lzfw_pkg::PH_ITEM:
                begin
                    if (!flags_reg[0])
                    begin
                        lit_load   = 1'b1;
                        flags_next = flags_shift;
                        phase_next = (flags_shift == lzfw_pkg::FLAGS_EMPTY)
                                   ? lzfw_pkg::PH_FLAG_LO : lzfw_pkg::PH_ITEM;
                    end
                    else
                    begin
                        held_next  = in_byte;
                        phase_next = lzfw_pkg::PH_TOKEN;
                    end
                end
                lzfw_pkg::PH_TOKEN:
                begin
                    tok_load   = 1'b1;
                    flags_next = flags_shift;
                    phase_next = (flags_shift == lzfw_pkg::FLAGS_EMPTY)
                               ? lzfw_pkg::PH_FLAG_LO : lzfw_pkg::PH_ITEM;
                end
                default:
                begin
                    phase_next = lzfw_pkg::PH_FLAG_LO;
                end
            endcase
        end
        if (in_fire && stream_end)
        begin
            phase_next = lzfw_pkg::PH_FLAG_LO;
            flags_next = lzfw_pkg::FLAGS_EMPTY;
            held_next  = 8'h00;
        end
    end

    // parser and ring pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_mode_reg <= 1'b0;
            phase_reg       <= lzfw_pkg::PH_FLAG_LO;
            flags_reg       <= lzfw_pkg::FLAGS_EMPTY;
            held_reg        <= 8'h00;
            wp_reg          <= '0;
            filled_reg      <= 1'b0;
            rd_idx_reg      <= '0;
            cnt_reg         <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                stored_mode_reg <= cfg_write_data;
            end
            phase_reg  <= phase_next;
            flags_reg  <= flags_next;
            held_reg   <= held_next;
            wp_reg     <= wp_next;
            filled_reg <= filled_next;
            if (tok_load)
            begin
                cnt_reg    <= tok_len;
                rd_idx_reg <= tok_start;
            end
            else if (issue)
            begin
                cnt_reg    <= cnt_reg - lzfw_pkg::CNT_W'(1);
                rd_idx_reg <= rd_idx_inc;
            end
        end
    end

    // emit stage: ring read data, a literal or a stored-mode byte waiting for the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (issue)
            begin
                e_valid_reg <= 1'b1;
            end
            else if (in_fire && (stored_mode_reg || lit_load))
            begin
                e_valid_reg <= 1'b1;
            end
            else if (e_fire)
            begin
                e_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (issue)
        begin
            e_from_mem_reg <= 1'b1;
            e_write_reg    <= 1'b1;
            e_last_reg     <= (cnt_reg == lzfw_pkg::CNT_W'(1));
            e_hit_reg      <= rd_hit;
            e_fwd_reg      <= rd_fwd;
            e_data_reg     <= e_byte;
        end
        else if (in_fire)
        begin
            e_from_mem_reg <= 1'b0;
            e_write_reg    <= !stored_mode_reg;
            e_last_reg     <= 1'b1;
            e_hit_reg      <= 1'b1;
            e_fwd_reg      <= 1'b0;
            e_data_reg     <= in_byte;
        end
    end

    // history ring: write the emitted byte, read ahead for the next copy byte
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wp_reg] <= e_byte;
        end
        if (issue)
        begin
            rd_data_reg <= ring_mem[rd_idx_reg];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (e_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_fire)
        begin
            out_byte_reg <= e_byte;
            run_last_reg <= e_last_reg;
        end
    end

endmodule

[hw/rtl/lzfw_checker.sv]
// Port-level checker for the flag-word decompressor, bound to the top level
`include "lz_flag_word_decompress_top_defines.svh"

module lzfw_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       run_last
);

    // hold a stalled output byte
    `LZFW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(run_last), "stalled output changed")

    // a new request is taken only once the previous run has reached its last byte
    `LZFW_ASSERT_SAME(a_ready_after_run, clk, rst_n, in_ready && out_valid, run_last, "request taken in mid-run")

    // ready drops only after a request was accepted
    `LZFW_ASSERT_SAME(a_ready_drop, clk, rst_n, $fell(in_ready), $past(in_valid && in_ready), "ready fell without a request")

endmodule

bind lz_flag_word_decompress_top lzfw_checker u_lzfw_checker (.*);
